>>> rtl/core/jpe_pkg.sv
package jpe_pkg;

    localparam int unsigned DEG_W  = 4;
    localparam int unsigned X_W    = 32;
    localparam int unsigned AB_W   = 13;   // Q4.8 plus headroom for the +1 shift
    localparam int unsigned VAL_W  = 48;
    localparam int unsigned NUM_W  = 52;
    localparam int unsigned ODATA_W = 56;

    localparam logic signed [63:0] LIM62 = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN48 = -64'sh0000_8000_0000_0000;
    localparam logic signed [47:0] ONE_Q24 = 48'sh0000_0100_0000;

    localparam logic [1:0] REG_MAX_ORDER = 2'd0;
    localparam logic [1:0] REG_ALPHA     = 2'd1;
    localparam logic [1:0] REG_BETA      = 2'd2;
    localparam logic [1:0] REG_MODE      = 2'd3;

    localparam logic [1:0] MODE_POLY    = 2'd0;
    localparam logic [1:0] MODE_SHIFTED = 2'd1;

    typedef enum logic [1:0] {SH_9, SH_15, SH_30, SH_32} t_shift;

    typedef struct packed {
        logic [3:0]         max_order;
        logic signed [11:0] alpha;
        logic signed [11:0] beta;
        logic [1:0]         mode;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [12:0] a;
        logic signed [12:0] b;
        logic signed [12:0] ab0;
        logic [3:0]         n;
        logic [3:0]         top;
        logic               deriv;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE, ST_OUT, ST_DMUL, ST_P1, ST_NUM, ST_DIV, ST_GX, ST_T12
    } t_state;

endpackage

>>> rtl/core/jpe_mul.sv
module jpe_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    input  jpe_pkg::t_shift    i_sh,
    output logic               o_busy,
    output logic               o_done,
    output logic signed [63:0] o_res,
    output logic               o_ov
);

    logic [63:0]      r_ua, r_ub;
    logic             r_neg;
    jpe_pkg::t_shift  r_sh;
    logic [127:0]     r_acc;
    logic [2:0]       r_cnt;
    logic             r_busy, r_done;
    logic signed [63:0] r_res;
    logic             r_ov;

    logic [31:0]  w_ah, w_bh;
    logic [63:0]  w_pp;
    logic [127:0] w_pps, w_sum, w_q;
    logic         w_ov;
    logic [61:0]  w_mag;

    // one 32x32 partial product per cycle
    always_comb begin
        w_ah = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
        w_bh = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
        w_pp = 64'(w_ah) * 64'(w_bh);
        unique case (r_cnt[1:0])
            2'b00:   w_pps = 128'(w_pp);
            2'b11:   w_pps = 128'(w_pp) << 64;
            default: w_pps = 128'(w_pp) << 32;
        endcase
    end

    // round half away from zero on the magnitude, then shift
    always_comb begin
        unique case (r_sh)
            jpe_pkg::SH_9:  begin w_sum = r_acc + (128'd1 << 8);  w_q = w_sum >> 9;  end
            jpe_pkg::SH_15: begin w_sum = r_acc + (128'd1 << 14); w_q = w_sum >> 15; end
            jpe_pkg::SH_30: begin w_sum = r_acc + (128'd1 << 29); w_q = w_sum >> 30; end
            default:        begin w_sum = r_acc + (128'd1 << 31); w_q = w_sum >> 32; end
        endcase
        w_ov  = |w_q[127:62];
        w_mag = w_ov ? jpe_pkg::LIM62[61:0] : w_q[61:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_ub  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg <= i_a[63] != i_b[63];
            r_sh  <= i_sh;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt == 3'd4) begin
                r_res <= r_neg ? -$signed(64'(w_mag)) : $signed(64'(w_mag));
                r_ov  <= w_ov;
            end else begin
                r_acc <= r_acc + w_pps;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_ov   = r_ov;

endmodule

>>> rtl/core/jpe_div.sv
module jpe_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [jpe_pkg::NUM_W-1:0] i_n,
    input  logic signed [jpe_pkg::NUM_W-1:0] i_d,
    output logic                             o_done,
    output logic signed [63:0]               o_res,
    output logic                             o_ov
);

    localparam int unsigned W   = jpe_pkg::NUM_W;
    localparam int unsigned DW  = W + 24;   // numerator scaled by 2^24
    localparam int unsigned CW  = $clog2(DW + 1);

    logic [DW-1:0] r_dvd;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_ud;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic signed [63:0] r_res;
    logic          r_ov;

    logic [W:0]    w_trial;
    logic          w_ge;
    logic          w_rnd, w_ov;
    logic [62:0]   w_q2;
    logic [61:0]   w_mag;

    always_comb begin
        w_trial = {r_rem[W-1:0], r_dvd[DW-1]};
        w_ge    = w_trial >= {1'b0, r_ud};
        w_rnd   = {r_rem, 1'b0} >= (W+2)'(r_ud);
        w_q2    = {1'b0, r_dvd[61:0]} + 63'(w_rnd);
        w_ov    = (|r_dvd[DW-1:62]) | w_q2[62];
        w_mag   = w_ov ? jpe_pkg::LIM62[61:0] : w_q2[61:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(DW)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {(i_n[W-1] ? W'(-i_n) : W'(i_n)), 24'd0};
            r_ud  <= i_d[W-1] ? W'(-i_d) : W'(i_d);
            r_rem <= '0;
            r_neg <= i_n[W-1] != i_d[W-1];
        end else if (r_busy) begin
            if (r_cnt == CW'(DW)) begin
                r_res <= r_neg ? -$signed(64'(w_mag)) : $signed(64'(w_mag));
                r_ov  <= w_ov;
            end else begin
                r_rem <= w_ge ? w_trial - {1'b0, r_ud} : w_trial;
                r_dvd <= {r_dvd[DW-2:0], w_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_ov   = r_ov;

endmodule

>>> rtl/core/jpe_front.sv
module jpe_front #(
    parameter int unsigned NCAP = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,
    input  jpe_pkg::t_cfg        i_cfg,
    input  logic                 i_pop,
    output logic                 o_job_valid,
    output jpe_pkg::t_job        o_job
);

    jpe_pkg::t_job r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    jpe_pkg::t_job w_job;
    logic          w_push, w_pop;
    logic signed [12:0] w_a0, w_b0;

    always_comb begin
        w_a0      = 13'(i_cfg.alpha);
        w_b0      = 13'(i_cfg.beta);
        w_job.x   = $signed(i_s_tdata);
        w_job.ab0 = w_a0 + w_b0;
        if (i_cfg.mode == jpe_pkg::MODE_SHIFTED) begin
            w_job.a = w_a0 + 13'sd256;
            w_job.b = w_b0 + 13'sd256;
        end else begin
            w_job.a = w_a0;
            w_job.b = w_b0;
        end
        w_job.n     = (i_cfg.max_order > 4'(NCAP)) ? 4'(NCAP) : i_cfg.max_order;
        w_job.deriv = i_cfg.mode != jpe_pkg::MODE_POLY;
        if (!w_job.deriv) begin
            w_job.top = w_job.n;
        end else begin
            w_job.top = (w_job.n != 4'd0) ? w_job.n - 4'd1 : 4'd0;
        end
    end

    assign o_s_tready  = r_cnt != 2'd2;
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = i_pop && (r_cnt != 2'd0);
    assign o_job_valid = r_cnt != 2'd0;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_job;
    end

endmodule

>>> rtl/core/jpe_back.sv
module jpe_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    input  jpe_pkg::t_job                  i_job,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [jpe_pkg::ODATA_W-1:0]    o_m_tdata,
    output logic                           o_m_tlast
);

    jpe_pkg::t_state r_state, n_state;
    jpe_pkg::t_job   r_job;
    logic [3:0]  r_j, r_k, r_step;
    logic [1:0]  r_dsel;
    logic        r_iss;
    logic signed [47:0] r_cur, r_prv, r_res_v;
    logic        r_cur_f, r_prv_f, r_res_f, r_f;
    logic signed [33:0] r_ta, r_tb, r_ts, r_tp, r_tu;
    logic signed [jpe_pkg::NUM_W-1:0] r_n2, r_n3, r_n4, r_den;
    logic signed [63:0] r_c1, r_c3, r_g, r_t1;
    logic        r_t2;   // second half of the T1/T2 product pair
    logic        r_m_valid, r_m_last;
    logic [jpe_pkg::ODATA_W-1:0] r_m_data;

    logic        w_slot;
    logic signed [17:0] w_s, w_u, w_pa, w_pb, w_jp1;
    logic signed [33:0] w_opa;
    logic signed [17:0] w_opb;
    logic signed [51:0] w_prod;
    logic signed [14:0] w_dfac;

    logic        w_mul_start, w_mul_busy, w_mul_done, w_mul_ov;
    logic signed [63:0] w_mul_a, w_mul_b, w_mul_res;
    jpe_pkg::t_shift w_mul_sh;
    logic        w_div_start, w_div_done, w_div_ov;
    logic signed [jpe_pkg::NUM_W-1:0] w_div_n;
    logic signed [63:0] w_div_res;

    logic signed [63:0] w_p1, w_gsum, w_diff;
    logic [48:0] w_p1s, w_dms, w_rcs;
    logic        w_g_ov;
    logic signed [63:0] w_g;
    logic        w_last_out;
    logic [3:0]  w_jn;

    function automatic logic [48:0] sat48(input logic signed [63:0] v);
        logic [48:0] r;
        if (v > jpe_pkg::MAX48) begin
            r = {1'b1, jpe_pkg::MAX48[47:0]};
        end else if (v < jpe_pkg::MIN48) begin
            r = {1'b1, jpe_pkg::MIN48[47:0]};
        end else begin
            r = {1'b0, v[47:0]};
        end
        return r;
    endfunction

    jpe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_sh    (w_mul_sh),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res),
        .o_ov    (w_mul_ov)
    );

    jpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (w_div_n),
        .i_d     (r_den),
        .o_done  (w_div_done),
        .o_res   (w_div_res),
        .o_ov    (w_div_ov)
    );

    // recurrence terms for step p = r_j
    always_comb begin
        w_s   = $signed({5'd0, r_j, 9'd0}) + 18'(r_job.a) + 18'(r_job.b);
        w_u   = $signed({5'd0, 5'(r_j) + 5'd1, 8'd0}) + 18'(r_job.a) + 18'(r_job.b);
        w_pa  = $signed({6'd0, r_j, 8'd0}) + 18'(r_job.a);
        w_pb  = $signed({6'd0, r_j, 8'd0}) + 18'(r_job.b);
        w_jp1 = $signed({13'd0, 5'(r_j) + 5'd1});
        unique case (r_step)
            4'd0:    begin w_opa = 34'(r_job.a);    w_opb = 18'(r_job.a); end
            4'd1:    begin w_opa = 34'(r_job.b);    w_opb = 18'(r_job.b); end
            4'd2:    begin w_opa = 34'(w_s);        w_opb = w_s + 18'sd256; end
            4'd3:    begin w_opa = 34'(w_pa);       w_opb = w_pb; end
            4'd4:    begin w_opa = 34'(w_jp1);      w_opb = w_u; end
            4'd5:    begin w_opa = r_ta - r_tb;     w_opb = w_s + 18'sd256; end
            4'd6:    begin w_opa = r_ts;            w_opb = w_s + 18'sd512; end
            4'd7:    begin w_opa = r_tp <<< 1;      w_opb = w_s + 18'sd512; end
            default: begin w_opa = r_tu <<< 1;      w_opb = w_s; end
        endcase
        w_prod = w_opa * w_opb;
        // derivative of degree k = r_j + 1 scales Q(r_j) by ab0 + 256*(k+1)
        w_dfac = 15'(r_job.ab0) + $signed({2'd0, 5'(r_j) + 5'd2, 8'd0});
    end

    always_comb begin
        w_p1   = ((64'(r_job.a) - 64'(r_job.b)) <<< 15) + w_mul_res;
        w_p1s  = sat48(w_p1);
        w_dms  = sat48(w_mul_res);
        w_gsum = r_c1 + w_mul_res;
        w_g_ov = (w_gsum > jpe_pkg::LIM62) || (w_gsum < -jpe_pkg::LIM62);
        if (w_gsum > jpe_pkg::LIM62)       w_g = jpe_pkg::LIM62;
        else if (w_gsum < -jpe_pkg::LIM62) w_g = -jpe_pkg::LIM62;
        else                               w_g = w_gsum;
        w_diff = r_t1 - w_mul_res;
        w_rcs  = sat48(w_diff);
        w_slot = !r_m_valid || i_m_tready;
        w_last_out = r_k == r_job.n;
        w_jn   = r_j + 4'd1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jpe_pkg::ST_IDLE: if (i_job_valid) n_state = jpe_pkg::ST_OUT;
            jpe_pkg::ST_OUT: begin
                if (w_slot) begin
                    if (w_last_out)                     n_state = jpe_pkg::ST_IDLE;
                    else if (r_job.deriv && r_k == 4'd0) n_state = jpe_pkg::ST_DMUL;
                    else if (r_j == 4'd0)               n_state = jpe_pkg::ST_P1;
                    else                                n_state = jpe_pkg::ST_NUM;
                end
            end
            jpe_pkg::ST_DMUL: if (w_mul_done) n_state = jpe_pkg::ST_OUT;
            jpe_pkg::ST_P1: begin
                if (w_mul_done) n_state = r_job.deriv ? jpe_pkg::ST_DMUL : jpe_pkg::ST_OUT;
            end
            jpe_pkg::ST_NUM: begin
                if (r_step == 4'd8) begin
                    if (w_prod != '0)     n_state = jpe_pkg::ST_DIV;
                    else if (r_job.deriv) n_state = jpe_pkg::ST_DMUL;
                    else                  n_state = jpe_pkg::ST_OUT;
                end
            end
            jpe_pkg::ST_DIV: if (w_div_done && r_dsel == 2'd2) n_state = jpe_pkg::ST_GX;
            jpe_pkg::ST_GX:  if (w_mul_done) n_state = jpe_pkg::ST_T12;
            jpe_pkg::ST_T12: begin
                if (w_mul_done && r_t2) n_state = r_job.deriv ? jpe_pkg::ST_DMUL : jpe_pkg::ST_OUT;
            end
            default: n_state = jpe_pkg::ST_IDLE;
        endcase
    end

    // unit controls
    always_comb begin
        o_pop       = (r_state == jpe_pkg::ST_IDLE) && i_job_valid;
        w_mul_start = 1'b0;
        w_mul_a     = 64'(r_g);
        w_mul_b     = 64'(r_cur);
        w_mul_sh    = jpe_pkg::SH_32;
        w_div_start = (r_state == jpe_pkg::ST_DIV) && !r_iss;
        unique case (r_dsel)
            2'd0:    w_div_n = r_n2;
            2'd1:    w_div_n = r_n3;
            default: w_div_n = r_n4;
        endcase
        unique case (r_state)
            jpe_pkg::ST_DMUL: begin
                w_mul_start = !r_iss;
                w_mul_a     = 64'(w_dfac);
                w_mul_sh    = jpe_pkg::SH_9;
            end
            jpe_pkg::ST_P1: begin
                w_mul_start = !r_iss;
                w_mul_a     = 64'(r_job.a) + 64'(r_job.b) + 64'sd512;
                w_mul_b     = 64'(r_job.x);
                w_mul_sh    = jpe_pkg::SH_15;
            end
            jpe_pkg::ST_GX: begin
                w_mul_start = !r_iss;
                w_mul_a     = r_g;
                w_mul_b     = 64'(r_job.x);
                w_mul_sh    = jpe_pkg::SH_30;
            end
            jpe_pkg::ST_T12: begin
                w_mul_start = !r_iss;
                if (r_t2) begin
                    w_mul_a = r_c3;
                    w_mul_b = 64'(r_prv);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= jpe_pkg::ST_IDLE;
            r_iss     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_mul_start || w_div_start)  r_iss <= 1'b1;
            else if (w_mul_done || w_div_done) r_iss <= 1'b0;
            if (r_state == jpe_pkg::ST_OUT && w_slot) r_m_valid <= 1'b1;
            else if (i_m_tready)                      r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            jpe_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    r_job   <= i_job;
                    r_j     <= 4'd0;
                    r_k     <= 4'd0;
                    r_cur   <= jpe_pkg::ONE_Q24;
                    r_cur_f <= 1'b0;
                    r_res_v <= i_job.deriv ? 48'sd0 : jpe_pkg::ONE_Q24;
                    r_res_f <= 1'b0;
                end
            end
            jpe_pkg::ST_OUT: begin
                if (w_slot) begin
                    r_m_data <= {3'd0, r_res_f, r_res_v, r_k};
                    r_m_last <= w_last_out;
                    r_step   <= 4'd0;
                    r_t2     <= 1'b0;
                end
            end
            jpe_pkg::ST_DMUL: begin
                if (w_mul_done) begin
                    r_res_v <= w_dms[47:0];
                    r_res_f <= r_cur_f | w_mul_ov | w_dms[48];
                    r_k     <= w_jn;
                end
            end
            jpe_pkg::ST_P1: begin
                if (w_mul_done) begin
                    r_prv   <= r_cur;
                    r_prv_f <= r_cur_f;
                    r_cur   <= w_p1s[47:0];
                    r_cur_f <= w_mul_ov | w_p1s[48];
                    r_j     <= w_jn;
                    r_res_v <= w_p1s[47:0];
                    r_res_f <= w_mul_ov | w_p1s[48];
                    r_k     <= w_jn;
                end
            end
            jpe_pkg::ST_NUM: begin
                r_step <= r_step + 4'd1;
                r_dsel <= 2'd0;
                if (r_step == 4'd0) r_f <= r_cur_f | r_prv_f;
                unique case (r_step)
                    4'd0:    r_ta  <= w_prod[33:0];
                    4'd1:    r_tb  <= w_prod[33:0];
                    4'd2:    r_ts  <= w_prod[33:0];
                    4'd3:    r_tp  <= w_prod[33:0];
                    4'd4:    r_tu  <= w_prod[33:0];
                    4'd5:    r_n2  <= w_prod;
                    4'd6:    r_n3  <= w_prod;
                    4'd7:    r_n4  <= w_prod;
                    default: r_den <= w_prod;
                endcase
                // zero denominator: result forced to zero, flagged
                if (r_step == 4'd8 && w_prod == '0) begin
                    r_prv   <= r_cur;
                    r_prv_f <= r_cur_f;
                    r_cur   <= '0;
                    r_cur_f <= 1'b1;
                    r_j     <= w_jn;
                    r_res_v <= '0;
                    r_res_f <= 1'b1;
                    r_k     <= w_jn;
                end
            end
            jpe_pkg::ST_DIV: begin
                if (w_div_done) begin
                    r_f    <= r_f | w_div_ov;
                    r_dsel <= r_dsel + 2'd1;
                    unique case (r_dsel)
                        2'd0:    r_c1 <= w_div_res;
                        2'd1:    r_g  <= w_div_res;   // c2 parked in r_g until used
                        default: r_c3 <= w_div_res;
                    endcase
                end
            end
            jpe_pkg::ST_GX: begin
                if (w_mul_done) begin
                    r_g <= w_g;
                    r_f <= r_f | w_mul_ov | w_g_ov;
                end
            end
            jpe_pkg::ST_T12: begin
                if (w_mul_done) begin
                    if (!r_t2) begin
                        r_t1 <= w_mul_res;
                        r_f  <= r_f | w_mul_ov;
                        r_t2 <= 1'b1;
                    end else begin
                        r_prv   <= r_cur;
                        r_prv_f <= r_cur_f;
                        r_cur   <= w_rcs[47:0];
                        r_cur_f <= r_f | w_mul_ov | w_rcs[48];
                        r_j     <= w_jn;
                        r_res_v <= w_rcs[47:0];
                        r_res_f <= r_f | w_mul_ov | w_rcs[48];
                        r_k     <= w_jn;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |-> !w_mul_busy)
        else $error("multiplier started while busy");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_start && w_div_start))
        else $error("multiplier and divider started together");

    a_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != jpe_pkg::ST_IDLE) |-> (r_j <= r_job.top))
        else $error("recurrence ran past its last degree");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jpe_pkg::ST_OUT && w_slot) |=> r_m_valid)
        else $error("result lost at output register");

endmodule

>>> rtl/core/jacobi_polynomial_evaluator_core.sv
// Jacobi polynomial evaluator.
// Slave stream: one abscissa per transfer, i_s_tdata = abscissa (signed Q2.30).
// Master stream: one transfer per degree k = 0..N, N = min(max_order, MAX_DEGREE);
//   o_m_tdata = {zeros, overflow, value (signed Q24.24, saturated), degree},
//   o_m_tlast marks degree N.
// Config port: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
//   (0 max_order, 1 alpha Q4.8, 2 beta Q4.8, 3 output_mode). Write only while idle.
// A two-entry input queue takes abscissae and snapshots the configuration;
// the back end runs the recurrence one degree at a time.
// Each degree from 2 up takes an output state, nine products for the numerators
// and the denominator, three bit-serial divisions and three split multiplies
// (a zero denominator skips the divisions and multiplies); the derivative modes add
// one more multiply per degree. Degree 0 is loaded into the output register in the
// output state after the item is taken; degree 1 follows after one more multiply.
// Reset clears the configuration to zero, empties the queue and the output.
// When the receiver stalls the result is held in the output register and the
// engine waits; the input queue keeps accepting until both entries are full.
module jacobi_polynomial_evaluator_core #(
    parameter int unsigned MAX_DEGREE = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,     // [31:0] abscissa
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,     // [3:0] degree, [51:4] value, [52] overflow
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata
);

    localparam int unsigned NCAP = (MAX_DEGREE > 15) ? 15 : MAX_DEGREE;

    jpe_pkg::t_cfg r_cfg;
    jpe_pkg::t_job w_job;
    logic          w_job_valid, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                jpe_pkg::REG_MAX_ORDER: r_cfg.max_order <= i_cfg_wdata[3:0];
                jpe_pkg::REG_ALPHA:     r_cfg.alpha     <= $signed(i_cfg_wdata);
                jpe_pkg::REG_BETA:      r_cfg.beta      <= $signed(i_cfg_wdata);
                jpe_pkg::REG_MODE:      r_cfg.mode      <= i_cfg_wdata[1:0];
            endcase
        end
    end

    jpe_front #(.NCAP(NCAP)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg       (r_cfg),
        .i_pop       (w_pop),
        .o_job_valid (w_job_valid),
        .o_job       (w_job)
    );

    jpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
